>>> rtl/oahs_pkg.sv
// Shared types and constants of the open-addressed hash set.
`default_nettype none
package oahs_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned HashW    = 32;
  localparam int unsigned KeyMaxB  = 8;
  localparam int unsigned HashMul  = 137;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [LenW-1:0]  len;
    logic [HashW-1:0] hash;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/open_address_hash_set.sv
// Top level of the open-addressed hash set with tombstones and rebuilds.
//  channel | signals                                   | dir
//  in      | in_valid_i/in_ready_o, operation_i,       | in
//          | key_value_i, key_length_i                 |
//  out     | out_valid_o/out_ready_i, ok_o,            | out
//          | table_full_o                              |
// A result is ready once the key is hashed byte by byte and the probe ends; the
// next item is accepted after the result is issued, after a rebuild when one is due.
// A rebuild clears the new bank's slots, reads each old slot, walks the
// probe steps of each moved entry and then swaps banks; the slot mark memory
// port sets the pace.
// After reset a clearing pass over the initial slots runs before the first item.
// One item at a time; a waiting result holds the next result, not the input.
`default_nettype none
module open_address_hash_set #(
  parameter int unsigned INIT_SIZE = 8,
  parameter int unsigned MAX_SIZE  = 1024,
  parameter int unsigned KEY_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] key_value_i,
  input  wire logic [3:0]  key_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic             table_full_o
);

  localparam int unsigned BankReq  = (MAX_SIZE > INIT_SIZE) ? MAX_SIZE : INIT_SIZE;
  localparam int unsigned IdxW     = $clog2(BankReq + 1) - 1;
  localparam int unsigned InitLog2 = $clog2(INIT_SIZE + 1) - 1;
  localparam int unsigned AW       = IdxW + 1;
  localparam int unsigned CW       = IdxW + 4;
  localparam int unsigned SLW      = $clog2(IdxW + 1);
  localparam int unsigned EW       = $bits(oahs_pkg::entry_t);
  localparam logic [IdxW:0] InitSlots = (IdxW + 1)'(1) << InitLog2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_DECIDE, S_RCLR, S_RRD, S_RCHK, S_RPCHK,
    S_RDONE, S_PSTART, S_PCHK, S_FIN, S_OUT
  } state_e;

  state_e                     state_q, state_d;
  logic [1:0]                 op_q, op_d;
  logic [63:0]                key_q, key_d;
  logic [3:0]                 len_q, len_d;
  logic [31:0]                hash_q, hash_d;
  logic [IdxW:0]              live_q, live_d, tomb_q, tomb_d, cnt_q, cnt_d, pi_q, pi_d;
  logic [SLW-1:0]             slog_q, slog_d, nlog_q, nlog_d;
  logic                       bank_q, bank_d;
  logic [IdxW-1:0]            idx_q, idx_d, tpos_q, tpos_d, pos_q, pos_d;
  logic                       has_tomb_q, has_tomb_d, found_q, found_d, nofree_q, nofree_d;
  logic                       at_lim_q, at_lim_d;
  logic                       out_valid_q, out_valid_d, ok_q, ok_d, full_q, full_d;
  logic                       rok_q, rok_d, rfull_q, rfull_d;

  logic                       mk_we, mk_re, en_we, en_re;
  logic [AW-1:0]              mk_waddr, mk_raddr, en_waddr, en_raddr;
  logic [1:0]                 mk_wdata, mk_rdata;
  oahs_pkg::entry_t           en_wdata, en_rdata;
  logic                       hs_start, hs_done;
  logic [31:0]                hs_hash;

  logic [3:0]                 len_c;
  logic [63:0]                key_c;
  logic [IdxW:0]              size_v, nsize_v;
  logic [IdxW-1:0]            mask_v, nmask_v, pnext, rnext;
  logic                       can_grow, lim_c, key_hit;

  oahs_ram #(.Width(2), .AddrW(AW)) u_mark (
    .clk_i, .we_i(mk_we), .waddr_i(mk_waddr), .wdata_i(mk_wdata),
    .re_i(mk_re), .raddr_i(mk_raddr), .rdata_o(mk_rdata)
  );

  oahs_ram #(.Width(EW), .AddrW(AW)) u_entry (
    .clk_i, .we_i(en_we), .waddr_i(en_waddr), .wdata_i(en_wdata),
    .re_i(en_re), .raddr_i(en_raddr), .rdata_o(en_rdata)
  );

  oahs_hash u_hash (
    .clk_i, .rst_ni, .start_i(hs_start), .key_i(key_q), .len_i(len_q),
    .done_o(hs_done), .hash_o(hs_hash)
  );

  always_comb begin
    len_c = (key_length_i > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length_i;
    for (int b = 0; b < 8; b++) begin
      key_c[8*b +: 8] = (4'(b) < len_c) ? key_value_i[8*b +: 8] : 8'h00;
    end
  end

  assign size_v   = (IdxW + 1)'(1) << slog_q;
  assign nsize_v  = (IdxW + 1)'(1) << nlog_q;
  assign mask_v   = size_v[IdxW-1:0] - 1'b1;
  assign nmask_v  = nsize_v[IdxW-1:0] - 1'b1;
  assign can_grow = slog_q < SLW'(IdxW);
  assign lim_c    = ((CW'(live_q) + 1'b1) << 2) >= CW'(size_v) * CW'(3);
  assign key_hit  = (en_rdata.key == key_q) && (en_rdata.len == len_q);
  assign pnext    = (idx_q + pi_q[IdxW-1:0] + 1'b1) & mask_v;
  assign rnext    = (idx_q + pi_q[IdxW-1:0] + 1'b1) & nmask_v;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign table_full_o = full_q;

  always_comb begin
    state_d = state_q;  op_d = op_q;  key_d = key_q;  len_d = len_q;  hash_d = hash_q;
    live_d = live_q;  tomb_d = tomb_q;  cnt_d = cnt_q;  pi_d = pi_q;
    slog_d = slog_q;  nlog_d = nlog_q;  bank_d = bank_q;  idx_d = idx_q;
    tpos_d = tpos_q;  pos_d = pos_q;  has_tomb_d = has_tomb_q;  found_d = found_q;
    nofree_d = nofree_q;  at_lim_d = at_lim_q;  rok_d = rok_q;  rfull_d = rfull_q;
    out_valid_d = out_valid_q && !out_ready_i;  ok_d = ok_q;  full_d = full_q;
    mk_we = 1'b0;  mk_re = 1'b0;  en_we = 1'b0;  en_re = 1'b0;
    mk_waddr = '0;  mk_raddr = '0;  en_waddr = '0;  en_raddr = '0;
    mk_wdata = oahs_pkg::MARK_EMPTY;  en_wdata = en_rdata;  hs_start = 1'b0;
    case (state_q)
      S_CLR: begin
        mk_we = 1'b1;
        mk_waddr = {1'b0, cnt_q[IdxW-1:0]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == InitSlots) begin
          cnt_d = '0;  state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i;  key_d = key_c;  len_d = len_c;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        hs_start = (cnt_q == '0);
        cnt_d = '1;
        if (hs_done) begin
          hash_d = hs_hash;  cnt_d = '0;  state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        nlog_d = slog_q;
        state_d = S_PSTART;
        case (op_q)
          oahs_pkg::OP_ADD: begin
            if (lim_c && can_grow) begin
              nlog_d = slog_q + 1'b1;  state_d = S_RCLR;
            end
          end
          oahs_pkg::OP_DEL: begin
            if (((CW'(tomb_q) + 1'b1) << 2) > CW'(size_v)) state_d = S_RCLR;
          end
          oahs_pkg::OP_QUERY: begin
            if (CW'(tomb_q) * CW'(3) >= CW'(size_v)) begin
              if ((CW'(live_q) << 2) >= CW'(size_v) * CW'(3) && can_grow) begin
                nlog_d = slog_q + 1'b1;
              end
              state_d = S_RCLR;
            end
          end
          default: begin
            rok_d = 1'b0;  rfull_d = 1'b0;  state_d = S_OUT;
          end
        endcase
      end
      S_RCLR: begin
        mk_we = 1'b1;
        mk_waddr = {~bank_q, cnt_q[IdxW-1:0]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == nsize_v) begin
          cnt_d = '0;  state_d = S_RRD;
        end
      end
      S_RRD: begin
        mk_re = 1'b1;  en_re = 1'b1;
        mk_raddr = {bank_q, cnt_q[IdxW-1:0]};
        en_raddr = {bank_q, cnt_q[IdxW-1:0]};
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (mk_rdata != oahs_pkg::MARK_LIVE) begin
          cnt_d = cnt_q + 1'b1;
          state_d = (cnt_q + 1'b1 == size_v) ? S_RDONE : S_RRD;
        end else begin
          idx_d = en_rdata.hash[IdxW-1:0] & nmask_v;
          pi_d = '0;
          mk_re = 1'b1;
          mk_raddr = {~bank_q, en_rdata.hash[IdxW-1:0] & nmask_v};
          state_d = S_RPCHK;
        end
      end
      S_RPCHK: begin
        if (mk_rdata == oahs_pkg::MARK_EMPTY) begin
          en_we = 1'b1;  en_waddr = {~bank_q, idx_q};
          mk_we = 1'b1;  mk_waddr = {~bank_q, idx_q};  mk_wdata = oahs_pkg::MARK_LIVE;
          cnt_d = cnt_q + 1'b1;
          state_d = (cnt_q + 1'b1 == size_v) ? S_RDONE : S_RRD;
        end else begin
          idx_d = rnext;  pi_d = pi_q + 1'b1;
          mk_re = 1'b1;  mk_raddr = {~bank_q, rnext};
        end
      end
      S_RDONE: begin
        slog_d = nlog_q;  bank_d = ~bank_q;  tomb_d = '0;  cnt_d = '0;
        state_d = S_PSTART;
      end
      S_PSTART: begin
        at_lim_d = lim_c;
        idx_d = hash_q[IdxW-1:0] & mask_v;
        pi_d = '0;  has_tomb_d = 1'b0;  tpos_d = '0;
        mk_re = 1'b1;  en_re = 1'b1;
        mk_raddr = {bank_q, hash_q[IdxW-1:0] & mask_v};
        en_raddr = {bank_q, hash_q[IdxW-1:0] & mask_v};
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (mk_rdata == oahs_pkg::MARK_EMPTY) begin
          found_d = 1'b0;  nofree_d = 1'b0;  pos_d = idx_q;  state_d = S_FIN;
        end else if (mk_rdata == oahs_pkg::MARK_LIVE && key_hit) begin
          found_d = 1'b1;  nofree_d = 1'b0;  pos_d = idx_q;  state_d = S_FIN;
        end else begin
          if (mk_rdata == oahs_pkg::MARK_TOMB && !has_tomb_q) begin
            has_tomb_d = 1'b1;  tpos_d = idx_q;
          end
          if (pi_q + 1'b1 == size_v) begin
            found_d = 1'b0;  nofree_d = 1'b1;  state_d = S_FIN;
          end else begin
            idx_d = pnext;  pi_d = pi_q + 1'b1;
            mk_re = 1'b1;  en_re = 1'b1;
            mk_raddr = {bank_q, pnext};  en_raddr = {bank_q, pnext};
          end
        end
      end
      S_FIN: begin
        rok_d = 1'b0;  rfull_d = 1'b0;
        state_d = S_OUT;
        case (op_q)
          oahs_pkg::OP_ADD: begin
            if (!found_q) begin
              if (at_lim_q || (!has_tomb_q && nofree_q)) begin
                rfull_d = 1'b1;
              end else begin
                en_we = 1'b1;  mk_we = 1'b1;  mk_wdata = oahs_pkg::MARK_LIVE;
                en_waddr = {bank_q, has_tomb_q ? tpos_q : pos_q};
                mk_waddr = {bank_q, has_tomb_q ? tpos_q : pos_q};
                en_wdata.key = key_q;  en_wdata.len = len_q;  en_wdata.hash = hash_q;
                if (has_tomb_q && tomb_q != '0) tomb_d = tomb_q - 1'b1;
                live_d = live_q + 1'b1;
                rok_d = 1'b1;
              end
            end
          end
          oahs_pkg::OP_DEL: begin
            if (found_q) begin
              mk_we = 1'b1;  mk_waddr = {bank_q, pos_q};  mk_wdata = oahs_pkg::MARK_TOMB;
              live_d = live_q - 1'b1;  tomb_d = tomb_q + 1'b1;
              rok_d = 1'b1;
            end
          end
          oahs_pkg::OP_QUERY: rok_d = found_q;
          default: rok_d = 1'b0;
        endcase
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;  ok_d = rok_q;  full_d = rfull_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;  live_q <= '0;  tomb_q <= '0;  cnt_q <= '0;
      slog_q <= SLW'(InitLog2);  nlog_q <= SLW'(InitLog2);  bank_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  live_q <= live_d;  tomb_q <= tomb_d;  cnt_q <= cnt_d;
      slog_q <= slog_d;  nlog_q <= nlog_d;  bank_q <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  key_q <= key_d;  len_q <= len_d;  hash_q <= hash_d;
    pi_q <= pi_d;  idx_q <= idx_d;  tpos_q <= tpos_d;  pos_q <= pos_d;
    has_tomb_q <= has_tomb_d;  found_q <= found_d;  nofree_q <= nofree_d;
    at_lim_q <= at_lim_d;  rok_q <= rok_d;  rfull_q <= rfull_d;
    ok_q <= ok_d;  full_q <= full_d;
  end

  a_full_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(ok_o && table_full_o)) else $error("full flag with success");
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(live_q) + CW'(tomb_q)) <= CW'(size_v)) else $error("occupancy above size");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (pi_q < size_v)) else $error("probe beyond table size");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result overwritten while waiting");

endmodule
`default_nettype wire

>>> rtl/oahs_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module oahs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/oahs_hash.sv
// Byte-serial polynomial hash, one byte per cycle.
`default_nettype none
module oahs_hash (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [oahs_pkg::KeyW-1:0]    key_i,
  input  wire logic [oahs_pkg::LenW-1:0]    len_i,
  output logic                              done_o,
  output logic      [oahs_pkg::HashW-1:0]   hash_o
);

  logic                          busy_q;
  logic [oahs_pkg::LenW-1:0]     b_q, len_q;
  logic [oahs_pkg::KeyW-1:0]     key_q;
  logic [oahs_pkg::HashW-1:0]    h_q;
  logic [7:0]                    byte_c;

  assign byte_c = key_q[{b_q[2:0], 3'b000} +: 8];
  assign done_o = busy_q && (b_q == len_q);
  assign hash_o = h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      b_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      b_q    <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      b_q <= b_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= '0;
      key_q <= key_i;
      len_q <= len_i;
    end else if (busy_q && !done_o) begin
      h_q <= h_q * oahs_pkg::HashW'(oahs_pkg::HashMul) + oahs_pkg::HashW'(byte_c);
    end
  end

endmodule
`default_nettype wire
